/* rtl/pcpi_pkg.sv */
package pcpi_pkg;

    localparam int COORD_BITS = 24;
    localparam int RAD_BITS   = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOTREM_BITS = DIFF_BITS + 3;
    localparam int NUM_BITS   = DIFF_BITS + RAD_BITS + 1;
    localparam int QUOT_BITS  = RAD_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + QUOT_BITS + 1;
    localparam int THR_BITS   = 2 * RAD_BITS + 4;
    localparam int CMP_BITS   = (SQ_BITS > THR_BITS) ? SQ_BITS : THR_BITS;
    localparam int ITER_BITS  = $clog2(NUM_BITS + 1);
    localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(100);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SQ_X,
        S_SQ_Y,
        S_TEST,
        S_ROOT,
        S_ROUND,
        S_MUL,
        S_DIV,
        S_ADD,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_CORNER_A,
        ST_EMIT_A,
        ST_CORNER_B,
        ST_NEWER,
        ST_EMIT_B,
        ST_LAST,
        ST_DONE
    } step_t;

    function automatic coord_t sat_coord(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lo = -hi - SUM_BITS'(1);
        if (v > hi)
        begin
            return coord_t'(hi);
        end
        else if (v < lo)
        begin
            return coord_t'(lo);
        end
        return coord_t'(v);
    endfunction

endpackage

/* rtl/pcpi_in_if.sv */
interface pcpi_in_if;
    logic                   valid;
    logic                   ready;
    pcpi_pkg::coord_t       point_x;
    pcpi_pkg::coord_t       point_y;
    logic                   path_last;

    modport source (output valid, point_x, point_y, path_last, input ready);
    modport sink   (input valid, point_x, point_y, path_last, output ready);
endinterface

/* rtl/pcpi_out_if.sv */
interface pcpi_out_if;
    logic                   valid;
    logic                   ready;
    pcpi_pkg::coord_t       out_x;
    pcpi_pkg::coord_t       out_y;
    logic                   inserted;
    logic                   run_end;
    logic                   path_end;

    modport source (output valid, out_x, out_y, inserted, run_end, path_end, input ready);
    modport sink   (input valid, out_x, out_y, inserted, run_end, path_end, output ready);
endinterface

/* rtl/path_corner_point_insertion_core.sv */
// path corner point insertion core
// in_pt carries one path point per beat (x, y, path_last); out_pt carries
// the refined path, one point per beat, with inserted, run_end and path_end.
// the first point of a path is passed on at once; each interior point is
// emitted once its successor arrives, preceded and followed by corner points
// at distance min_curve_radius when the neighbor lies at least 3 radii away.
// the point flagged path_last is appended with path_end set.
// cfg_wr_en / cfg_wr_data write min_curve_radius (reset value 100); write
// only while the core is idle.
// a start-of-path point passes through the dispatch and emit states into the
// output register once its beat is accepted; an interior point takes two corner
// evaluations, each at most a 25-step bit-pair square root and then two 42-step
// restoring divisions sharing one divide unit.
// one point is in flight at a time; in_pt.ready is high only when idle, and
// the next point is taken while the last result still sits in the output
// register.
// a stalled receiver holds the output register; the sequencer waits for it.
// reset (rst_n low, asynchronous) clears the history, the radius to 100 and
// drops out_pt.valid.
module path_corner_point_insertion_core (
    input  logic                            clk,
    input  logic                            rst_n,
    pcpi_in_if.sink                         in_pt,
    pcpi_out_if.source                      out_pt,
    input  logic                            cfg_wr_en,
    input  logic [pcpi_pkg::RAD_BITS-1:0]   cfg_wr_data
);

    localparam int DW  = pcpi_pkg::DIFF_BITS;
    localparam int SW  = pcpi_pkg::SQ_BITS;
    localparam int RMW = pcpi_pkg::ROOTREM_BITS;
    localparam int NW  = pcpi_pkg::NUM_BITS;
    localparam int QW  = pcpi_pkg::QUOT_BITS;
    localparam int UW  = pcpi_pkg::SUM_BITS;
    localparam int RB  = pcpi_pkg::RAD_BITS;
    localparam int TW  = pcpi_pkg::THR_BITS;
    localparam int CMW = pcpi_pkg::CMP_BITS;
    localparam int IW  = pcpi_pkg::ITER_BITS;

    pcpi_pkg::state_t state_reg, state_next;
    pcpi_pkg::step_t  step_reg;

    // configuration and path history
    logic [RB-1:0]      radius_reg;
    pcpi_pkg::coord_t   older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic [1:0]         seen_reg;

    // current point
    pcpi_pkg::coord_t   cur_x_reg, cur_y_reg;
    logic               cur_last_reg;

    // corner arithmetic
    logic [DW-1:0]      ax_reg, ay_reg;
    logic               negx_reg, negy_reg;
    logic [SW-1:0]      sq_reg, s_reg;
    logic [2*RB-1:0]    r2_reg;
    logic [RMW-1:0]     rrem_reg;
    logic [DW-1:0]      root_reg, len_reg;
    logic [NW-1:0]      num_reg;
    logic [DW:0]        drem_reg;
    logic [IW-1:0]      iter_reg;
    logic               comp_reg;
    pcpi_pkg::coord_t   cres_x_reg, cres_y_reg;
    logic               cpass_reg;

    // pending beat
    pcpi_pkg::coord_t   em_x_reg, em_y_reg;
    logic               em_ins_reg, em_run_reg, em_pend_reg;

    // output register
    logic               ov_reg;
    pcpi_pkg::coord_t   ox_reg, oy_reg;
    logic               oins_reg, orun_reg, opend_reg;

    logic               in_fire;
    logic               out_free;

    // sequencer decisions
    logic               d_emit, d_calc, d_done, d_use_older;
    pcpi_pkg::step_t    d_step;
    pcpi_pkg::coord_t   d_x, d_y;
    logic               d_ins, d_run, d_pend;

    // arithmetic helpers
    logic signed [DW-1:0] dx_w, dy_w;
    pcpi_pkg::coord_t     nb_x, nb_y;
    logic [RMW-1:0]       rrem_sh, rtrial;
    logic [DW:0]          drem_sh;
    logic [CMW-1:0]       s_ext, thr_ext;
    logic [TW-1:0]        thr_w;
    logic [DW-1:0]        a_sel;
    logic                 neg_sel;
    logic signed [UW-1:0] sum_w, base_w, off_w;
    pcpi_pkg::coord_t     base_sel;

    assign in_fire  = in_pt.valid && in_pt.ready;
    assign out_free = !ov_reg || out_pt.ready;

    assign in_pt.ready     = (state_reg == pcpi_pkg::S_IDLE);
    assign out_pt.valid    = ov_reg;
    assign out_pt.out_x    = ox_reg;
    assign out_pt.out_y    = oy_reg;
    assign out_pt.inserted = oins_reg;
    assign out_pt.run_end  = orun_reg;
    assign out_pt.path_end = opend_reg;

    // step dispatch
    always_comb
    begin
        d_emit      = 1'b0;
        d_calc      = 1'b0;
        d_done      = 1'b0;
        d_use_older = 1'b0;
        d_step      = step_reg;
        d_x         = cur_x_reg;
        d_y         = cur_y_reg;
        d_ins       = 1'b0;
        d_run       = 1'b0;
        d_pend      = 1'b0;
        case (step_reg)
            pcpi_pkg::ST_FIRST:
            begin
                d_emit = 1'b1;
                d_run  = !cur_last_reg;
                d_step = cur_last_reg ? pcpi_pkg::ST_LAST : pcpi_pkg::ST_DONE;
            end
            pcpi_pkg::ST_CORNER_A:
            begin
                d_calc      = 1'b1;
                d_use_older = 1'b1;
                d_step      = pcpi_pkg::ST_EMIT_A;
            end
            pcpi_pkg::ST_EMIT_A:
            begin
                d_emit = cpass_reg;
                d_x    = cres_x_reg;
                d_y    = cres_y_reg;
                d_ins  = 1'b1;
                d_step = pcpi_pkg::ST_CORNER_B;
            end
            pcpi_pkg::ST_CORNER_B:
            begin
                d_calc = 1'b1;
                d_step = pcpi_pkg::ST_NEWER;
            end
            pcpi_pkg::ST_NEWER:
            begin
                d_emit = 1'b1;
                d_x    = newer_x_reg;
                d_y    = newer_y_reg;
                d_run  = !cur_last_reg && !cpass_reg;
                if (cpass_reg)
                begin
                    d_step = pcpi_pkg::ST_EMIT_B;
                end
                else
                begin
                    d_step = cur_last_reg ? pcpi_pkg::ST_LAST : pcpi_pkg::ST_DONE;
                end
            end
            pcpi_pkg::ST_EMIT_B:
            begin
                d_emit = 1'b1;
                d_x    = cres_x_reg;
                d_y    = cres_y_reg;
                d_ins  = 1'b1;
                d_run  = !cur_last_reg;
                d_step = cur_last_reg ? pcpi_pkg::ST_LAST : pcpi_pkg::ST_DONE;
            end
            pcpi_pkg::ST_LAST:
            begin
                d_emit = 1'b1;
                d_run  = 1'b1;
                d_pend = 1'b1;
                d_step = pcpi_pkg::ST_DONE;
            end
            default:
            begin
                d_done = 1'b1;
            end
        endcase
    end

    // datapath helpers
    assign nb_x  = d_use_older ? older_x_reg : cur_x_reg;
    assign nb_y  = d_use_older ? older_y_reg : cur_y_reg;
    assign dx_w  = DW'($signed(nb_x)) - DW'($signed(newer_x_reg));
    assign dy_w  = DW'($signed(nb_y)) - DW'($signed(newer_y_reg));

    assign thr_w   = TW'({r2_reg, 3'b000}) + TW'(r2_reg);
    assign s_ext   = CMW'(s_reg);
    assign thr_ext = CMW'(thr_w);

    // bit-pair square root step
    assign rrem_sh = {rrem_reg[RMW-3:0], s_reg[SW-1:SW-2]};
    assign rtrial  = RMW'({root_reg, 2'b01});

    // restoring divide step
    assign drem_sh = {drem_reg[DW-1:0], num_reg[NW-1]};

    assign a_sel    = comp_reg ? ay_reg : ax_reg;
    assign neg_sel  = comp_reg ? negy_reg : negx_reg;
    assign base_sel = comp_reg ? newer_y_reg : newer_x_reg;
    assign base_w   = UW'(base_sel);
    assign off_w    = neg_sel ? -$signed(UW'(num_reg[QW-1:0]))
                              : $signed(UW'(num_reg[QW-1:0]));
    assign sum_w    = base_w + off_w;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcpi_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = pcpi_pkg::S_DISPATCH;
                end
            end
            pcpi_pkg::S_DISPATCH:
            begin
                if (d_done)
                begin
                    state_next = pcpi_pkg::S_IDLE;
                end
                else if (d_emit)
                begin
                    state_next = pcpi_pkg::S_EMIT;
                end
                else if (d_calc)
                begin
                    state_next = pcpi_pkg::S_SQ_X;
                end
            end
            pcpi_pkg::S_SQ_X: state_next = pcpi_pkg::S_SQ_Y;
            pcpi_pkg::S_SQ_Y: state_next = pcpi_pkg::S_TEST;
            pcpi_pkg::S_TEST:
            begin
                state_next = (s_ext < thr_ext) ? pcpi_pkg::S_DISPATCH : pcpi_pkg::S_ROOT;
            end
            pcpi_pkg::S_ROOT:
            begin
                if (iter_reg == IW'(DW - 1))
                begin
                    state_next = pcpi_pkg::S_ROUND;
                end
            end
            pcpi_pkg::S_ROUND: state_next = pcpi_pkg::S_MUL;
            pcpi_pkg::S_MUL:
            begin
                state_next = (len_reg == '0) ? pcpi_pkg::S_ADD : pcpi_pkg::S_DIV;
            end
            pcpi_pkg::S_DIV:
            begin
                if (iter_reg == IW'(NW - 1))
                begin
                    state_next = pcpi_pkg::S_ADD;
                end
            end
            pcpi_pkg::S_ADD:
            begin
                state_next = comp_reg ? pcpi_pkg::S_DISPATCH : pcpi_pkg::S_MUL;
            end
            pcpi_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = pcpi_pkg::S_DISPATCH;
                end
            end
            default: state_next = pcpi_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pcpi_pkg::S_IDLE;
            step_reg    <= pcpi_pkg::ST_DONE;
            radius_reg  <= pcpi_pkg::RADIUS_RESET;
            older_x_reg <= '0;
            older_y_reg <= '0;
            newer_x_reg <= '0;
            newer_y_reg <= '0;
            seen_reg    <= '0;
            ov_reg      <= 1'b0;
            iter_reg    <= '0;
            comp_reg    <= 1'b0;
            cpass_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            // load a new beat, else drop the one just taken
            if (state_reg == pcpi_pkg::S_EMIT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_pt.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                pcpi_pkg::S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (seen_reg)
                            2'd0:    step_reg <= pcpi_pkg::ST_FIRST;
                            2'd1:    step_reg <= in_pt.path_last ? pcpi_pkg::ST_LAST
                                                                 : pcpi_pkg::ST_DONE;
                            default: step_reg <= pcpi_pkg::ST_CORNER_A;
                        endcase
                    end
                end
                pcpi_pkg::S_DISPATCH:
                begin
                    step_reg <= d_step;
                    if (d_calc)
                    begin
                        cpass_reg <= 1'b0;
                    end
                    if (d_done)
                    begin
                        if (cur_last_reg)
                        begin
                            seen_reg <= '0;
                        end
                        else
                        begin
                            older_x_reg <= newer_x_reg;
                            older_y_reg <= newer_y_reg;
                            newer_x_reg <= cur_x_reg;
                            newer_y_reg <= cur_y_reg;
                            if (seen_reg != 2'd2)
                            begin
                                seen_reg <= seen_reg + 2'd1;
                            end
                        end
                    end
                end
                pcpi_pkg::S_TEST:
                begin
                    iter_reg <= '0;
                end
                pcpi_pkg::S_ROOT:
                begin
                    iter_reg <= iter_reg + IW'(1);
                end
                pcpi_pkg::S_ROUND:
                begin
                    comp_reg <= 1'b0;
                end
                pcpi_pkg::S_MUL:
                begin
                    iter_reg <= '0;
                end
                pcpi_pkg::S_DIV:
                begin
                    iter_reg <= iter_reg + IW'(1);
                end
                pcpi_pkg::S_ADD:
                begin
                    comp_reg <= 1'b1;
                    if (comp_reg)
                    begin
                        cpass_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pcpi_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cur_x_reg    <= in_pt.point_x;
                    cur_y_reg    <= in_pt.point_y;
                    cur_last_reg <= in_pt.path_last;
                end
            end
            pcpi_pkg::S_DISPATCH:
            begin
                em_x_reg    <= d_x;
                em_y_reg    <= d_y;
                em_ins_reg  <= d_ins;
                em_run_reg  <= d_run;
                em_pend_reg <= d_pend;
                negx_reg    <= dx_w[DW-1];
                negy_reg    <= dy_w[DW-1];
                ax_reg      <= dx_w[DW-1] ? DW'(-dx_w) : DW'(dx_w);
                ay_reg      <= dy_w[DW-1] ? DW'(-dy_w) : DW'(dy_w);
            end
            pcpi_pkg::S_SQ_X:
            begin
                sq_reg <= SW'(ax_reg * ax_reg);
                r2_reg <= radius_reg * radius_reg;
            end
            pcpi_pkg::S_SQ_Y:
            begin
                s_reg <= sq_reg + SW'(ay_reg * ay_reg);
            end
            pcpi_pkg::S_TEST:
            begin
                rrem_reg <= '0;
                root_reg <= '0;
            end
            pcpi_pkg::S_ROOT:
            begin
                s_reg <= {s_reg[SW-3:0], 2'b00};
                if (rrem_sh >= rtrial)
                begin
                    rrem_reg <= rrem_sh - rtrial;
                    root_reg <= {root_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= rrem_sh;
                    root_reg <= {root_reg[DW-2:0], 1'b0};
                end
            end
            pcpi_pkg::S_ROUND:
            begin
                len_reg <= (rrem_reg > RMW'(root_reg)) ? root_reg + DW'(1) : root_reg;
            end
            pcpi_pkg::S_MUL:
            begin
                drem_reg <= '0;
                if (len_reg == '0)
                begin
                    num_reg <= '0;
                end
                else
                begin
                    num_reg <= NW'(a_sel * radius_reg) + NW'(len_reg >> 1);
                end
            end
            pcpi_pkg::S_DIV:
            begin
                if (drem_sh >= {1'b0, len_reg})
                begin
                    drem_reg <= drem_sh - {1'b0, len_reg};
                    num_reg  <= {num_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    num_reg  <= {num_reg[NW-2:0], 1'b0};
                end
            end
            pcpi_pkg::S_ADD:
            begin
                if (comp_reg)
                begin
                    cres_y_reg <= pcpi_pkg::sat_coord(sum_w);
                end
                else
                begin
                    cres_x_reg <= pcpi_pkg::sat_coord(sum_w);
                end
            end
            pcpi_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    ox_reg    <= em_x_reg;
                    oy_reg    <= em_y_reg;
                    oins_reg  <= em_ins_reg;
                    orun_reg  <= em_run_reg;
                    opend_reg <= em_pend_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/pcpi_checker.sv */
module pcpi_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  pcpi_pkg::coord_t            out_x,
    input  logic                        out_run_end,
    input  logic                        out_path_end,
    input  logic                        out_inserted
);

    // a stalled beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its x coordinate and run_end flag
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_run_end))
        else $error("output payload changed while stalled");

    // one point in flight: no second accept right after one
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a point is in flight");

    // the path's final point closes its run and is an original point
    a_path_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_path_end |-> out_run_end && !out_inserted)
        else $error("path end beat without run end or marked inserted");

endmodule

bind path_corner_point_insertion_core pcpi_checker u_pcpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_pt.valid),
    .in_ready     (in_pt.ready),
    .out_valid    (out_pt.valid),
    .out_ready    (out_pt.ready),
    .out_x        (out_pt.out_x),
    .out_run_end  (out_pt.run_end),
    .out_path_end (out_pt.path_end),
    .out_inserted (out_pt.inserted)
);
